// ===== design/assembly_source_tokenizer_defines.svh =====
// assertion helpers for the assembly source tokenizer
`ifndef ASSEMBLY_SOURCE_TOKENIZER_DEFINES_SVH
`define ASSEMBLY_SOURCE_TOKENIZER_DEFINES_SVH

// general clocked check, quiet while reset is held
`define ATOK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on the result waiting at the head of the output queue
`define ATOK_ASSERT_HEAD(label, cond, prop, msg) \
  `ATOK_ASSERT(label, (!empty && (cond)) |-> (prop), msg)

`endif

// ===== design/atok_pkg.sv =====
`timescale 1ns / 1ps
package atok_pkg;

  // input operation codes
  typedef enum logic [1:0] {
    OP_CHAR = 2'd0,
    OP_EOL  = 2'd1,
    OP_EOF  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // token kinds
  localparam logic [3:0] K_COLON    = 4'd0;
  localparam logic [3:0] K_COMMA    = 4'd1;
  localparam logic [3:0] K_DOT      = 4'd2;
  localparam logic [3:0] K_DOLLAR   = 4'd3;
  localparam logic [3:0] K_MINUS    = 4'd4;
  localparam logic [3:0] K_EQUALS   = 4'd5;
  localparam logic [3:0] K_LPAREN   = 4'd6;
  localparam logic [3:0] K_RPAREN   = 4'd7;
  localparam logic [3:0] K_LBRACKET = 4'd8;
  localparam logic [3:0] K_RBRACKET = 4'd9;
  localparam logic [3:0] K_NEWLINE  = 4'd10;
  localparam logic [3:0] K_EOF      = 4'd11;
  localparam logic [3:0] K_STRING   = 4'd12;
  localparam logic [3:0] K_NUMBER   = 4'd13;
  localparam logic [3:0] K_IDENT    = 4'd14;
  localparam logic [3:0] K_ERROR    = 4'd15;

  // error codes
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_SYMBOL = 3'd1;
  localparam logic [2:0] ERR_QUOTE  = 3'd2;
  localparam logic [2:0] ERR_BASE   = 3'd3;
  localparam logic [2:0] ERR_LONG   = 3'd4;

  // queue depths
  localparam int unsigned FQ_DEPTH = 4;
  localparam int unsigned RQ_DEPTH = 4;

  // classified input transaction, front to back
  typedef struct packed {
    op_e        op;
    logic       punct;
    logic [3:0] pidx;
    logic       quote;
    logic       zero;
    logic       digit;
    logic       alpha;
    logic       hash;
    logic       space;
    logic       idcont;
    logic       base_x;
    logic       base_o;
    logic       base_b;
    logic       hexd;
    logic       octd;
    logic       bdig;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] line;
    logic [8:0]  column;
    logic [8:0]  length;
    logic [2:0]  err;
    logic        last;
  } res_t;

endpackage

// ===== design/atok_front.sv =====
`timescale 1ns / 1ps
module atok_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [1:0]     op_i,
  input  logic [7:0]     ch_i,
  output logic           full_o,
  input  logic           deq_i,
  output logic           valid_o,
  output atok_pkg::item_t item_o
);
  import atok_pkg::*;

  localparam int unsigned PTR_W = $clog2(FQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(FQ_DEPTH + 1);

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_D0      = 8'h30;
  localparam logic [7:0] CH_D1      = 8'h31;
  localparam logic [7:0] CH_D7      = 8'h37;
  localparam logic [7:0] CH_D9      = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_B    = 8'h42;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_UP_O    = 8'h4F;
  localparam logic [7:0] CH_UP_X    = 8'h58;
  localparam logic [7:0] CH_UP_Z    = 8'h5A;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_B    = 8'h62;
  localparam logic [7:0] CH_LO_F    = 8'h66;
  localparam logic [7:0] CH_LO_O    = 8'h6F;
  localparam logic [7:0] CH_LO_X    = 8'h78;
  localparam logic [7:0] CH_LO_Z    = 8'h7A;

  // character classification
  function automatic item_t classify(logic [1:0] op, logic [7:0] ch);
    item_t it;
    it        = '0;
    it.op     = op_e'(op);
    it.digit  = (ch >= CH_D0) && (ch <= CH_D9);
    it.zero   = (ch == CH_D0);
    it.alpha  = ((ch >= CH_LO_A) && (ch <= CH_LO_Z)) || ((ch >= CH_UP_A) && (ch <= CH_UP_Z));
    it.quote  = (ch == CH_QUOTE);
    it.hash   = (ch == CH_HASH);
    it.space  = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    it.idcont = it.alpha || it.digit || (ch == CH_UNDER);
    it.base_x = (ch == CH_LO_X) || (ch == CH_UP_X);
    it.base_o = (ch == CH_LO_O) || (ch == CH_UP_O);
    it.base_b = (ch == CH_LO_B) || (ch == CH_UP_B);
    it.hexd   = it.digit || ((ch >= CH_LO_A) && (ch <= CH_LO_F))
                || ((ch >= CH_UP_A) && (ch <= CH_UP_F));
    it.octd   = (ch >= CH_D0) && (ch <= CH_D7);
    it.bdig   = (ch == CH_D0) || (ch == CH_D1);
    it.punct  = 1'b1;
    unique case (ch)
      CH_COLON:  it.pidx = K_COLON;
      CH_COMMA:  it.pidx = K_COMMA;
      CH_DOT:    it.pidx = K_DOT;
      CH_DOLLAR: it.pidx = K_DOLLAR;
      CH_MINUS:  it.pidx = K_MINUS;
      CH_EQUALS: it.pidx = K_EQUALS;
      CH_LPAREN: it.pidx = K_LPAREN;
      CH_RPAREN: it.pidx = K_RPAREN;
      CH_LBRACK: it.pidx = K_LBRACKET;
      CH_RBRACK: it.pidx = K_RBRACKET;
      default: begin
        it.punct = 1'b0;
        it.pidx  = K_COLON;
      end
    endcase
    return it;
  endfunction

  item_t             mem_q [FQ_DEPTH];
  logic [PTR_W-1:0]  wp_q, rp_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              wr, rd;

  assign full_o  = (cnt_q == CNT_W'(FQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rp_q];
  assign wr      = push_i && !full_o;
  assign rd      = deq_i && valid_o;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= classify(op_i, ch_i);
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) begin
        wp_q <= wp_q + PTR_W'(1);
      end
      if (rd) begin
        rp_q <= rp_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(wr) - CNT_W'(rd);
    end
  end

endmodule

// ===== design/atok_back.sv =====
`timescale 1ns / 1ps
module atok_back #(
  parameter int unsigned LINE_LEN   = 256,
  parameter int unsigned LINE_COUNT = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  atok_pkg::item_t item_i,
  input  logic            room_i,
  output logic            take_o,
  output logic [1:0]      res_n_o,
  output atok_pkg::res_t  res0_o,
  output atok_pkg::res_t  res1_o
);
  import atok_pkg::*;

  localparam int unsigned COL_W = $clog2(LINE_LEN + 1);
  localparam int unsigned LN_W  = $clog2(LINE_COUNT);

  typedef enum logic [3:0] {
    S_IDLE, S_IDENT, S_DEC, S_ZERO, S_HEX, S_OCT, S_BIN, S_STRING, S_COMMENT, S_ERROR
  } mode_e;

  function automatic res_t mk(logic [3:0] k, logic [8:0] c, logic [8:0] l, logic [2:0] e,
                              logic [15:0] ln);
    res_t r;
    r.kind   = k;
    r.line   = ln;
    r.column = c;
    r.length = l;
    r.err    = e;
    r.last   = 1'b0;
    return r;
  endfunction

  mode_e            mode_q, mode_d;
  logic [COL_W-1:0] start_q, start_d, colc_q, colc_d;
  logic [LN_W-1:0]  line_q, line_d, line_inc;
  logic [15:0]      line16, line_inc16;
  logic [COL_W-1:0] tok_len;
  logic [8:0]       col9, start9, tok9, str9, base_col9, nl_col9;
  logic             cv, cerr, sv, ext, v0, v1;
  res_t             cres, sres, r0, r1, fin;
  mode_e            s_mode;

  assign take_o = valid_i && room_i;

  // line numbers, columns and lengths
  always_comb begin
    line16     = (32'(line_q) > 32'hFFFF) ? 16'hFFFF : 16'(line_q);
    line_inc   = (32'(line_q) < (LINE_COUNT - 1)) ? line_q + LN_W'(1) : line_q;
    line_inc16 = (32'(line_inc) > 32'hFFFF) ? 16'hFFFF : 16'(line_inc);
    tok_len    = colc_q - start_q;
    col9       = 9'(colc_q);
    start9     = 9'(start_q);
    tok9       = 9'(tok_len);
    str9       = 9'(tok_len - COL_W'(1));
    base_col9  = 9'({1'b0, start_q} + (COL_W + 1)'(2));
    nl_col9    = 9'({1'b0, colc_q} + (COL_W + 1)'(1));
  end

  // closing a pending identifier or number
  always_comb begin
    cv   = 1'b0;
    cerr = 1'b0;
    cres = '0;
    case (mode_q)
      S_IDENT: begin
        cv   = 1'b1;
        cres = mk(K_IDENT, start9, tok9, ERR_NONE, line16);
      end
      S_DEC, S_ZERO: begin
        cv   = 1'b1;
        cres = mk(K_NUMBER, start9, tok9, ERR_NONE, line16);
      end
      S_HEX, S_OCT, S_BIN: begin
        cv = 1'b1;
        if (tok_len <= COL_W'(2)) begin
          cerr = 1'b1;
          cres = mk(K_ERROR, base_col9, 9'd0, ERR_BASE, line16);
        end else begin
          cres = mk(K_NUMBER, start9, tok9, ERR_NONE, line16);
        end
      end
      default: ;
    endcase
  end

  // token continuation and start of a new token
  always_comb begin
    case (mode_q)
      S_IDENT: ext = item_i.idcont;
      S_ZERO:  ext = item_i.base_x || item_i.base_o || item_i.base_b || item_i.digit;
      S_DEC:   ext = item_i.digit;
      S_HEX:   ext = item_i.hexd;
      S_OCT:   ext = item_i.octd;
      S_BIN:   ext = item_i.bdig;
      default: ext = 1'b0;
    endcase
    sv     = 1'b0;
    sres   = '0;
    s_mode = S_IDLE;
    if (item_i.punct) begin
      sv   = 1'b1;
      sres = mk(item_i.pidx, col9, 9'd1, ERR_NONE, line16);
    end else if (item_i.quote) begin
      s_mode = S_STRING;
    end else if (item_i.zero) begin
      s_mode = S_ZERO;
    end else if (item_i.digit) begin
      s_mode = S_DEC;
    end else if (item_i.alpha) begin
      s_mode = S_IDENT;
    end else if (item_i.hash) begin
      s_mode = S_COMMENT;
    end else if (!item_i.space) begin
      sv     = 1'b1;
      sres   = mk(K_ERROR, col9, 9'd0, ERR_SYMBOL, line16);
      s_mode = S_ERROR;
    end
  end

  // scanner next state and results
  always_comb begin
    mode_d  = mode_q;
    start_d = start_q;
    colc_d  = colc_q;
    line_d  = line_q;
    v0      = 1'b0;
    v1      = 1'b0;
    r0      = '0;
    r1      = '0;
    fin     = '0;
    case (item_i.op)
      OP_CHAR: begin
        if (mode_q != S_ERROR) begin
          if (colc_q >= COL_W'(LINE_LEN)) begin
            v0     = 1'b1;
            r0     = mk(K_ERROR, col9, 9'd0, ERR_LONG, line16);
            mode_d = S_ERROR;
          end else begin
            colc_d = colc_q + COL_W'(1);
            if (mode_q == S_COMMENT) begin
              mode_d = S_COMMENT;
            end else if (mode_q == S_STRING) begin
              if (item_i.quote) begin
                v0     = 1'b1;
                r0     = mk(K_STRING, start9, str9, ERR_NONE, line16);
                mode_d = S_IDLE;
              end
            end else if (ext) begin
              if (mode_q == S_ZERO) begin
                if (item_i.base_x) begin
                  mode_d = S_HEX;
                end else if (item_i.base_o) begin
                  mode_d = S_OCT;
                end else if (item_i.base_b) begin
                  mode_d = S_BIN;
                end else begin
                  mode_d = S_DEC;
                end
              end
            end else if (cerr) begin
              v0     = 1'b1;
              r0     = cres;
              mode_d = S_ERROR;
            end else begin
              mode_d = s_mode;
              if (!item_i.punct) begin
                start_d = colc_q;
              end
              if (cv) begin
                v0 = 1'b1;
                r0 = cres;
                v1 = sv;
                r1 = sres;
              end else begin
                v0 = sv;
                r0 = sres;
              end
            end
          end
        end
      end
      OP_EOL, OP_EOF: begin
        if (mode_q != S_ERROR) begin
          if (mode_q == S_STRING) begin
            v0     = 1'b1;
            r0     = mk(K_ERROR, start9, 9'd0, ERR_QUOTE, line16);
            mode_d = S_ERROR;
          end else if (cerr) begin
            v0     = 1'b1;
            r0     = cres;
            mode_d = S_ERROR;
          end else begin
            v0 = cv;
            r0 = cres;
            if (item_i.op == OP_EOL) begin
              fin    = mk(K_NEWLINE, nl_col9, 9'd1, ERR_NONE, line16);
              colc_d = '0;
              mode_d = S_IDLE;
              line_d = line_inc;
            end else begin
              fin = mk(K_EOF, 9'd0, 9'd0, ERR_NONE,
                       (colc_q != '0) ? line_inc16 : line16);
            end
            if (v0) begin
              v1 = 1'b1;
              r1 = fin;
            end else begin
              v0 = 1'b1;
              r0 = fin;
            end
          end
        end
        // end of file always returns to the reset state
        if (item_i.op == OP_EOF) begin
          mode_d  = S_IDLE;
          start_d = '0;
          colc_d  = '0;
          line_d  = '0;
        end
      end
      default: ;
    endcase
    if (v1) begin
      r1.last = 1'b1;
    end else if (v0) begin
      r0.last = 1'b1;
    end
  end

  assign res_n_o = take_o ? (2'(v0) + 2'(v1)) : 2'd0;
  assign res0_o  = r0;
  assign res1_o  = r1;

  // scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= S_IDLE;
      start_q <= '0;
      colc_q  <= '0;
      line_q  <= '0;
    end else if (take_o) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      colc_q  <= colc_d;
      line_q  <= line_d;
    end
  end

endmodule

// ===== design/atok_resq.sv =====
`timescale 1ns / 1ps
module atok_resq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     wr_n_i,
  input  atok_pkg::res_t wr0_i,
  input  atok_pkg::res_t wr1_i,
  output logic           room_o,
  output logic           empty_o,
  input  logic           pop_i,
  output atok_pkg::res_t head_o
);
  import atok_pkg::*;

  localparam int unsigned PTR_W = $clog2(RQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(RQ_DEPTH + 1);

  res_t             mem_q [RQ_DEPTH];
  logic [PTR_W-1:0] wp_q, rp_q;
  logic [CNT_W-1:0] cnt_q;
  logic             rd;

  // room for a transaction that gives two results
  assign room_o  = (cnt_q <= CNT_W'(RQ_DEPTH - 2));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rp_q];
  assign rd      = pop_i && !empty_o;

  // result storage, up to two writes a cycle
  always_ff @(posedge clk_i) begin
    if (wr_n_i != 2'd0) begin
      mem_q[wp_q] <= wr0_i;
    end
    if (wr_n_i == 2'd2) begin
      mem_q[wp_q + PTR_W'(1)] <= wr1_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + PTR_W'(wr_n_i);
      if (rd) begin
        rp_q <= rp_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(wr_n_i) - CNT_W'(rd);
    end
  end

endmodule

// ===== design/assembly_source_tokenizer.sv =====
`timescale 1ns / 1ps
// Streaming assembly lexer: one transaction per cycle is pushed while full is low (a
// source character, an end of line or an end of file) and tokens come out of a result
// queue as kind, line, start column and length, with last marking the final result of
// a transaction. A transaction is classified as it is written into its input queue
// (four deep); the scanner takes it from the queue head and writes its results into the
// result queue, from which they are popped. The scanner retires one transaction per
// cycle whenever the four-deep result queue has room for two results. Sustained rate is
// one transaction per cycle, limited only by the single-result pop port when two results
// come from one transaction. After an error all input up to end of file is dropped; end
// of file restores the reset state. Reset takes effect at once; there is no clearing pass.
`include "assembly_source_tokenizer_defines.svh"
module assembly_source_tokenizer #(
  parameter int unsigned LINE_LEN   = 256,
  parameter int unsigned LINE_COUNT = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op_i,
  input  logic [7:0]  ch_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  kind_o,
  output logic [15:0] line_number_o,
  output logic [8:0]  column_o,
  output logic [8:0]  length_o,
  output logic [2:0]  error_code_o,
  output logic        last_o
);
  import atok_pkg::*;

  logic  fq_valid, bk_take, rq_room;
  item_t fq_item;
  logic [1:0] res_n;
  res_t  res0, res1, head;

  // classifier and input queue
  atok_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (op_i),
    .ch_i    (ch_i),
    .full_o  (full),
    .deq_i   (bk_take),
    .valid_o (fq_valid),
    .item_o  (fq_item)
  );

  // scanner
  atok_back #(
    .LINE_LEN   (LINE_LEN),
    .LINE_COUNT (LINE_COUNT)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fq_valid),
    .item_i  (fq_item),
    .room_i  (rq_room),
    .take_o  (bk_take),
    .res_n_o (res_n),
    .res0_o  (res0),
    .res1_o  (res1)
  );

  // result queue
  atok_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_n_i  (res_n),
    .wr0_i   (res0),
    .wr1_i   (res1),
    .room_o  (rq_room),
    .empty_o (empty),
    .pop_i   (pop),
    .head_o  (head)
  );

  assign kind_o        = head.kind;
  assign line_number_o = head.line;
  assign column_o      = head.column;
  assign length_o      = head.length;
  assign error_code_o  = head.err;
  assign last_o        = head.last;

  // checks
  `ATOK_ASSERT_HEAD(a_err_code, kind_o == K_ERROR, error_code_o != ERR_NONE && length_o == 9'd0, "error result without code")
  `ATOK_ASSERT_HEAD(a_no_code, kind_o != K_ERROR, error_code_o == ERR_NONE, "error code on a token")
  `ATOK_ASSERT_HEAD(a_eof_last, kind_o == K_EOF || kind_o == K_NEWLINE, last_o, "line or file end not last")
  `ATOK_ASSERT(a_take_room, bk_take |-> rq_room, "scanner retired without result room")

endmodule

// ===== tb/tb_assembly_source_tokenizer.sv =====
`timescale 1ns / 1ps
module tb_assembly_source_tokenizer;
  import atok_pkg::*;

  localparam int LINE_LEN    = 256;
  localparam int LINE_COUNT  = 65536;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [15:0] LINE_TOP = 16'(LINE_COUNT - 1);

  // scanner modes of the lexer being predicted
  typedef enum logic [3:0] {
    SC_IDLE, SC_IDENT, SC_DEC, SC_ZERO, SC_HEX, SC_OCT, SC_BIN, SC_STRING, SC_COMMENT,
    SC_ERROR
  } scan_e;

  // one source transaction waiting to be pushed
  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
  } src_item_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  op_i = OP_NONE;
  logic [7:0]  ch_i = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  kind_o;
  logic [15:0] line_number_o;
  logic [8:0]  column_o;
  logic [8:0]  length_o;
  logic [2:0]  error_code_o;
  logic        last_o;

  src_item_t source_q[$];
  res_t      want_tokens[$];
  res_t      head_want;

  // predicted lexer state
  scan_e       scan = SC_IDLE;
  logic [8:0]  tok_start = '0;
  logic [8:0]  col_cnt = '0;
  logic [15:0] line_cnt = '0;
  res_t        step_buf[2];
  int          step_n;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int n_queued = 0;
  int n_accepted = 0;
  int n_files = 0;
  int n_tokens = 0;
  int n_err_tokens = 0;
  int mismatches = 0;
  int cycle_cnt = 0;

  assembly_source_tokenizer #(
    .LINE_LEN  (LINE_LEN),
    .LINE_COUNT(LINE_COUNT)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .op_i         (op_i),
    .ch_i         (ch_i),
    .empty        (empty),
    .pop          (pop),
    .kind_o       (kind_o),
    .line_number_o(line_number_o),
    .column_o     (column_o),
    .length_o     (length_o),
    .error_code_o (error_code_o),
    .last_o       (last_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // character classes
  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit base_ok(scan_e m, logic [7:0] c);
    if (m == SC_HEX) return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    if (m == SC_OCT) return c >= "0" && c <= "7";
    return c == "0" || c == "1";
  endfunction

  // punctuation lookup: found flag over the kind
  function automatic logic [4:0] punct_of(logic [7:0] c);
    case (c)
      ":":     return {1'b1, K_COLON};
      ",":     return {1'b1, K_COMMA};
      ".":     return {1'b1, K_DOT};
      "$":     return {1'b1, K_DOLLAR};
      "-":     return {1'b1, K_MINUS};
      "=":     return {1'b1, K_EQUALS};
      "(":     return {1'b1, K_LPAREN};
      ")":     return {1'b1, K_RPAREN};
      "[":     return {1'b1, K_LBRACKET};
      "]":     return {1'b1, K_RBRACKET};
      default: return 5'd0;
    endcase
  endfunction

  function automatic void emit_tok(logic [3:0] k, logic [8:0] col, logic [8:0] len,
                                   logic [2:0] e);
    res_t r;
    r.kind   = k;
    r.line   = line_cnt;
    r.column = col;
    r.length = len;
    r.err    = e;
    r.last   = 1'b0;
    step_buf[step_n] = r;
    step_n++;
  endfunction

  function automatic void raise_err(logic [8:0] col, logic [2:0] e);
    emit_tok(K_ERROR, col, 9'd0, e);
    scan = SC_ERROR;
  endfunction

  function automatic void clear_scan();
    scan      = SC_IDLE;
    tok_start = '0;
    col_cnt   = '0;
    line_cnt  = '0;
  endfunction

  // close a pending identifier or number ending before col
  function automatic void close_tok(logic [8:0] col);
    logic [8:0] span;
    span = col - tok_start;
    case (scan)
      SC_IDENT: begin
        emit_tok(K_IDENT, tok_start, span, ERR_NONE);
        scan = SC_IDLE;
      end
      SC_DEC, SC_ZERO: begin
        emit_tok(K_NUMBER, tok_start, span, ERR_NONE);
        scan = SC_IDLE;
      end
      SC_HEX, SC_OCT, SC_BIN: begin
        if (span <= 9'd2) begin
          raise_err(tok_start + 9'd2, ERR_BASE);
        end else begin
          emit_tok(K_NUMBER, tok_start, span, ERR_NONE);
          scan = SC_IDLE;
        end
      end
      default: ;
    endcase
  endfunction

  // start of a new token from idle
  function automatic void scan_idle(logic [7:0] c, logic [8:0] col);
    logic [4:0] p;
    p = punct_of(c);
    if (p[4]) begin
      emit_tok(p[3:0], col, 9'd1, ERR_NONE);
      return;
    end
    tok_start = col;
    if (c == "\"") scan = SC_STRING;
    else if (c == "0") scan = SC_ZERO;
    else if (is_dig(c)) scan = SC_DEC;
    else if (is_alpha(c)) scan = SC_IDENT;
    else if (c == "#") scan = SC_COMMENT;
    else if (!is_blank(c)) raise_err(col, ERR_SYMBOL);
  endfunction

  function automatic void scan_char(logic [7:0] c);
    logic [8:0] col;
    col = col_cnt;
    if (col >= LINE_LEN) begin
      raise_err(col, ERR_LONG);
      return;
    end
    col_cnt = col + 9'd1;
    if (scan == SC_COMMENT) return;
    if (scan == SC_STRING) begin
      if (c == "\"") begin
        emit_tok(K_STRING, tok_start, col - tok_start - 9'd1, ERR_NONE);
        scan = SC_IDLE;
      end
      return;
    end
    if (scan == SC_IDENT && (is_alpha(c) || is_dig(c) || c == "_")) return;
    if (scan == SC_ZERO) begin
      if (c == "x" || c == "X") begin
        scan = SC_HEX;
        return;
      end
      if (c == "o" || c == "O") begin
        scan = SC_OCT;
        return;
      end
      if (c == "b" || c == "B") begin
        scan = SC_BIN;
        return;
      end
      if (is_dig(c)) begin
        scan = SC_DEC;
        return;
      end
    end
    if (scan == SC_DEC && is_dig(c)) return;
    if ((scan == SC_HEX || scan == SC_OCT || scan == SC_BIN) && base_ok(scan, c)) return;
    close_tok(col);
    if (scan == SC_IDLE) scan_idle(c, col);
  endfunction

  // finish the open line, 0 when that raised an error
  function automatic bit finish_line();
    if (scan == SC_STRING) begin
      raise_err(tok_start, ERR_QUOTE);
      return 1'b0;
    end
    if (scan == SC_COMMENT) begin
      scan = SC_IDLE;
      return 1'b1;
    end
    close_tok(col_cnt);
    return scan != SC_ERROR;
  endfunction

  // predicted tokens for one accepted transaction
  function automatic void tokenize(op_e op, logic [7:0] c);
    res_t r;
    step_n = 0;
    case (op)
      OP_CHAR: begin
        if (scan != SC_ERROR) scan_char(c);
      end
      OP_EOL: begin
        if (scan != SC_ERROR) begin
          if (finish_line()) begin
            emit_tok(K_NEWLINE, col_cnt + 9'd1, 9'd1, ERR_NONE);
            if (line_cnt != LINE_TOP) line_cnt++;
            col_cnt = '0;
            scan    = SC_IDLE;
          end
        end
      end
      OP_EOF: begin
        if (scan != SC_ERROR) begin
          if (finish_line()) begin
            if (col_cnt != 9'd0 && line_cnt != LINE_TOP) line_cnt++;
            emit_tok(K_EOF, 9'd0, 9'd0, ERR_NONE);
          end
        end
        clear_scan();
      end
      default: ;
    endcase
    for (int i = 0; i < step_n; i++) begin
      r = step_buf[i];
      r.last = (i == step_n - 1);
      want_tokens.push_back(r);
    end
  endfunction

  // source generation
  function automatic void add_item(op_e op, logic [7:0] c);
    src_item_t it;
    it.op = op;
    it.ch = c;
    source_q.push_back(it);
    n_queued++;
  endfunction

  function automatic void add_op(op_e op);
    add_item(op, 8'($urandom_range(255, 0)));
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_item(OP_CHAR, s[i]);
  endfunction

  function automatic logic [7:0] pick_char(string s);
    return s[$urandom_range(s.len() - 1, 0)];
  endfunction

  function automatic logic [7:0] rand_alpha();
    return pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ");
  endfunction

  function automatic void add_noise();
    repeat ($urandom_range(6, 0)) begin
      case ($urandom_range(2, 0))
        0:       add_op(OP_CHAR);
        1:       add_op(OP_EOL);
        default: add_op(OP_NONE);
      endcase
    end
  endfunction

  // one well-formed token; 1 when it opened a comment
  function automatic bit gen_token();
    int pick;
    logic [7:0] b;
    logic [7:0] c;
    pick = $urandom_range(99, 0);
    if (pick < 20) begin
      add_item(OP_CHAR, pick_char(":,.$-=()[]"));
    end else if (pick < 45) begin
      add_item(OP_CHAR, rand_alpha());
      repeat ($urandom_range(7, 0)) begin
        case ($urandom_range(3, 0))
          0:       add_item(OP_CHAR, pick_char("0123456789"));
          1:       add_item(OP_CHAR, "_");
          default: add_item(OP_CHAR, rand_alpha());
        endcase
      end
    end else if (pick < 60) begin
      add_item(OP_CHAR, pick_char("0123456789"));
      repeat ($urandom_range(4, 0)) add_item(OP_CHAR, pick_char("0123456789"));
    end else if (pick < 75) begin
      b = pick_char("xXoObB");
      add_item(OP_CHAR, "0");
      add_item(OP_CHAR, b);
      repeat ($urandom_range(6, 1)) begin
        if (b == "x" || b == "X") add_item(OP_CHAR, pick_char("0123456789abcdefABCDEF"));
        else if (b == "o" || b == "O") add_item(OP_CHAR, pick_char("01234567"));
        else add_item(OP_CHAR, pick_char("01"));
      end
    end else if (pick < 85) begin
      add_item(OP_CHAR, "\"");
      repeat ($urandom_range(8, 0)) begin
        c = 8'($urandom_range(255, 0));
        if (c == "\"") c = "'";
        add_item(OP_CHAR, c);
      end
      add_item(OP_CHAR, "\"");
    end else if (pick < 92) begin
      add_item(OP_CHAR, "#");
      repeat ($urandom_range(6, 0)) add_op(OP_CHAR);
      return 1'b1;
    end else begin
      add_item(OP_CHAR, pick_char(" \t\n\r"));
      if ($urandom_range(1, 0) == 0) add_item(OP_CHAR, 8'd11);
      else add_item(OP_CHAR, 8'd12);
    end
    return 1'b0;
  endfunction

  function automatic void gen_line(bit close);
    int n;
    n = $urandom_range(7, 0);
    for (int k = 0; k < n; k++) begin
      if (gen_token()) break;
      if ($urandom_range(9, 0) < 7) add_item(OP_CHAR, " ");
    end
    if ($urandom_range(19, 0) == 0) add_op(OP_NONE);
    if (close) add_op(OP_EOL);
  endfunction

  // a usually broken piece of source, then noise and end of file
  function automatic void gen_fault();
    case ($urandom_range(9, 0))
      0, 1, 2: add_op(OP_CHAR);
      3, 4: begin
        add_item(OP_CHAR, "\"");
        repeat ($urandom_range(4, 0)) add_item(OP_CHAR, rand_alpha());
      end
      5, 6: begin
        add_item(OP_CHAR, "0");
        add_item(OP_CHAR, pick_char("xXoObB"));
        if ($urandom_range(1, 0) == 0) add_op(OP_EOL);
        else add_item(OP_CHAR, pick_char(" :,g9"));
      end
      7: add_text("0xg");
      8: add_item(OP_CHAR, pick_char("@!%^&*+/;<>?`{|}~\\'"));
      default: repeat ($urandom_range(260, 257)) add_item(OP_CHAR, pick_char("ab  "));
    endcase
    add_noise();
    add_op(OP_EOF);
  endfunction

  function automatic void gen_file();
    int lines;
    int fault_at;
    lines = $urandom_range(5, 1);
    fault_at = ($urandom_range(3, 0) == 0) ? $urandom_range(lines - 1, 0) : -1;
    for (int l = 0; l < lines; l++) begin
      if (l == fault_at) begin
        gen_fault();
        return;
      end
      gen_line(l < lines - 1 || $urandom_range(4, 0) != 0);
    end
    add_op(OP_EOF);
  endfunction

  // driver: push pending source transactions, predicting each accepted one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        tokenize(op_e'(op_i), ch_i);
        n_accepted++;
        if (op_i == OP_EOF) n_files++;
      end
      if (push && full) begin
        // hold the offered transaction
      end else if (source_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        push <= 1'b1;
        op_i <= source_q[0].op;
        ch_i <= source_q[0].ch;
        void'(source_q.pop_front());
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor: pop tokens and compare with the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_tokens++;
        if (kind_o == K_ERROR) n_err_tokens++;
        if (want_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected token: kind %0d line %0d col %0d len %0d err %0d last %0d",
                     kind_o, line_number_o, column_o, length_o, error_code_o, last_o);
        end else begin
          head_want = want_tokens.pop_front();
          if (kind_o !== head_want.kind || line_number_o !== head_want.line ||
              column_o !== head_want.column || length_o !== head_want.length ||
              error_code_o !== head_want.err || last_o !== head_want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("token %0d expected kind %0d line %0d col %0d len %0d err %0d last %0d",
                       n_tokens, head_want.kind, head_want.line, head_want.column,
                       head_want.length, head_want.err, head_want.last);
              $display("token %0d got      kind %0d line %0d col %0d len %0d err %0d last %0d",
                       n_tokens, kind_o, line_number_o, column_o, length_o, error_code_o,
                       last_o);
            end
          end
        end
      end
      // long hold-off on request, random stalls otherwise
      if (hold_served != hold_asked) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens outstanding", cycle_cnt,
               want_tokens.size());
      $display("tb_assembly_source_tokenizer: done, errors");
      $finish;
    end
  end

  // wait until every queued transaction is in and every token is out
  task automatic drain();
    while (source_q.size() > 0 || push || want_tokens.size() > 0) @(posedge clk_i);
  endtask

  task automatic random_phase(int idle, int stall, int count);
    int start;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    start = n_queued;
    while (n_queued - start < count) gen_file();
    drain();
  endtask

  // stimulus sequence
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every punctuation mark, each token kind, each error kind but the over-long line
    add_text(":,.$-=()[]");
    add_op(OP_EOL);
    add_text("a_1\"s\"0XfF 0o7,0B1 09#c");
    add_op(OP_EOL);
    add_op(OP_NONE);
    add_text("ab");
    add_op(OP_EOF);
    add_text("0x");
    add_op(OP_EOL);
    add_text("q");
    add_op(OP_EOF);
    add_text("\"ab");
    add_op(OP_EOF);
    add_text("0b2");
    add_op(OP_EOF);
    add_item(OP_CHAR, 8'hFF);
    add_op(OP_EOF);
    add_text("\t@");
    add_op(OP_EOF);
    add_op(OP_EOF);
    drain();

    // full-width lines, with the receiver held off so the queues fill
    hold_asked++;
    repeat (256) add_item(OP_CHAR, "a");
    add_op(OP_EOL);
    add_item(OP_CHAR, "\"");
    repeat (254) add_item(OP_CHAR, "z");
    add_item(OP_CHAR, "\"");
    add_op(OP_EOL);
    add_op(OP_EOF);
    repeat (256) add_item(OP_CHAR, " ");
    add_text("x");
    add_op(OP_EOF);
    drain();

    // random source under each idling pattern
    random_phase(0, 0, 215);
    random_phase(46, 0, 215);
    random_phase(0, 46, 215);
    random_phase(30, 30, 215);

    repeat (16) @(posedge clk_i);
    $display("pushed %0d source transactions over %0d files, popped %0d tokens (%0d errors)",
             n_accepted, n_files, n_tokens, n_err_tokens);
    $display("covered all token and error kinds, full-width lines, long hold-off, stalls");
    if (mismatches == 0 && want_tokens.size() == 0) begin
      $display("tb_assembly_source_tokenizer: done, clean");
    end else begin
      $display("%0d mismatches, %0d tokens missing", mismatches, want_tokens.size());
      $display("tb_assembly_source_tokenizer: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/atok_pkg.sv
design/atok_front.sv
design/atok_back.sv
design/atok_resq.sv
design/assembly_source_tokenizer.sv
tb/tb_assembly_source_tokenizer.sv
